### hdl/pearson_correlation_unit_core_assert.svh
// Assertion macros shared by the checker of the Pearson correlation unit.
`ifndef PEARSON_CORRELATION_UNIT_CORE_ASSERT_SVH
`define PEARSON_CORRELATION_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PCU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PCU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pcu_pkg.sv
// Package of the Pearson correlation unit: sizes, codes and shared types.
`timescale 1ns / 1ps

package pcu_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int EFF_BITS    = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam int SEXT_SHIFT  = 16 - EFF_BITS;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = 26;
    localparam int SQ_W    = 42;
    localparam int MUL_W   = 52;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int VAR_W   = 53;
    localparam int REM_W   = PROD_W + 1;
    localparam int QUO_W   = 31;
    localparam int ROOT_W  = 16;
    localparam int BIT_W   = $clog2(ROOT_W);
    localparam int STEP_W  = 6;

    localparam int MUL_STEPS = MUL_W;

    // Controller states, one-hot
    typedef enum logic [9:0] {
        ST_ACCUM     = 10'b00_0000_0001,
        ST_FLUSH     = 10'b00_0000_0010,
        ST_MUL_LOAD  = 10'b00_0000_0100,
        ST_MUL_RUN   = 10'b00_0000_1000,
        ST_MUL_SAVE  = 10'b00_0001_0000,
        ST_CHECK     = 10'b00_0010_0000,
        ST_DIV_RUN   = 10'b00_0100_0000,
        ST_SQRT_LOAD = 10'b00_1000_0000,
        ST_SQRT_RUN  = 10'b01_0000_0000,
        ST_RESULT    = 10'b10_0000_0000
    } pcu_state_t;

    // Multiply operations of the final evaluation, in issue order
    typedef enum logic [2:0] {
        OP_NSAA = 3'd0,
        OP_SASA = 3'd1,
        OP_NSBB = 3'd2,
        OP_SBSB = 3'd3,
        OP_NSAB = 3'd4,
        OP_SASB = 3'd5,
        OP_VAVB = 3'd6,
        OP_MAG2 = 3'd7
    } pcu_op_t;

    typedef struct packed {
        logic             take;
        logic             mul_load;
        logic             mul_step;
        logic             mul_capture;
        pcu_op_t          op;
        logic             div_load;
        logic             div_step;
        logic             sqrt_load;
        logic             sqrt_step;
        logic [BIT_W-1:0] sqrt_bit;
        logic             out_load;
    } pcu_cmd_t;

    typedef struct packed {
        logic zero_var;
        logic out_free;
    } pcu_stat_t;

endpackage

### hdl/pcu_ctrl.sv
// Controller state machine of the Pearson correlation unit.
`timescale 1ns / 1ps

module pcu_ctrl
    import pcu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      last_sample,
    input  pcu_stat_t stat,
    output logic      in_stall,
    output pcu_cmd_t  cmd
);

    pcu_state_t         state_reg, state_next;
    pcu_op_t            op_reg, op_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;

    // Hold state, operation index and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            op_reg    <= OP_NSAA;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != ST_ACCUM);

    // Sequence accumulation, multiplies, divide, root and result
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                cmd.take = in_valid;
                if (in_valid && last_sample)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                op_next    = OP_NSAA;
                state_next = ST_MUL_LOAD;
            end
            ST_MUL_LOAD:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_MUL_RUN;
            end
            ST_MUL_RUN:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_MUL_SAVE;
                end
            end
            ST_MUL_SAVE:
            begin
                cmd.mul_capture = 1'b1;
                if (op_reg == OP_MAG2)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    op_next    = pcu_op_t'(op_reg + 3'd1);
                    state_next = ST_MUL_LOAD;
                end
            end
            ST_CHECK:
            begin
                if (stat.zero_var)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(QUO_W - 1))
                begin
                    state_next = ST_SQRT_LOAD;
                end
            end
            ST_SQRT_LOAD:
            begin
                cmd.sqrt_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT_RUN;
            end
            ST_SQRT_RUN:
            begin
                cmd.sqrt_step = 1'b1;
                cmd.sqrt_bit  = BIT_W'(ROOT_W - 1) - cnt_reg[BIT_W-1:0];
                cnt_next      = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

### hdl/pcu_datapath.sv
// Datapath of the Pearson correlation unit: accumulators, shared multiplier,
// divider, square root and output register.
`timescale 1ns / 1ps

module pcu_datapath
    import pcu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [15:0] sample_a,
    input  logic signed [15:0] sample_b,
    input  pcu_cmd_t           cmd,
    output pcu_stat_t          stat,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [15:0] correlation,
    output logic               zero_variance,
    output logic               too_many_samples
);

    // Input stage: sign-extended samples and their products
    logic signed [15:0] a_ext, b_ext;
    logic signed [31:0] aa_w, bb_w, ab_w;

    assign a_ext = $signed(sample_a << SEXT_SHIFT) >>> SEXT_SHIFT;
    assign b_ext = $signed(sample_b << SEXT_SHIFT) >>> SEXT_SHIFT;
    assign aa_w  = a_ext * a_ext;
    assign bb_w  = b_ext * b_ext;
    assign ab_w  = a_ext * b_ext;

    logic               s1_valid_reg;
    logic signed [15:0] s1_a_reg, s1_b_reg;
    logic signed [31:0] s1_aa_reg, s1_bb_reg, s1_ab_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            s1_a_reg  <= a_ext;
            s1_b_reg  <= b_ext;
            s1_aa_reg <= aa_w;
            s1_bb_reg <= bb_w;
            s1_ab_reg <= ab_w;
        end
    end

    // Accumulators: drop pairs past the limit, clear after each result
    logic [CNT_W-1:0]        pair_count_reg;
    logic signed [SUM_W-1:0] sum_a_reg, sum_b_reg;
    logic [SQ_W-1:0]         sum_sq_a_reg, sum_sq_b_reg;
    logic signed [SQ_W-1:0]  sum_product_reg;
    logic                    overflow_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg    <= '0;
            sum_a_reg         <= '0;
            sum_b_reg         <= '0;
            sum_sq_a_reg      <= '0;
            sum_sq_b_reg      <= '0;
            sum_product_reg   <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            pair_count_reg    <= '0;
            sum_a_reg         <= '0;
            sum_b_reg         <= '0;
            sum_sq_a_reg      <= '0;
            sum_sq_b_reg      <= '0;
            sum_product_reg   <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            if (pair_count_reg == CNT_W'(MAX_SAMPLES))
            begin
                overflow_seen_reg <= 1'b1;
            end
            else
            begin
                pair_count_reg  <= pair_count_reg + CNT_W'(1);
                sum_a_reg       <= sum_a_reg + SUM_W'(s1_a_reg);
                sum_b_reg       <= sum_b_reg + SUM_W'(s1_b_reg);
                sum_sq_a_reg    <= sum_sq_a_reg + SQ_W'(unsigned'(s1_aa_reg));
                sum_sq_b_reg    <= sum_sq_b_reg + SQ_W'(unsigned'(s1_bb_reg));
                sum_product_reg <= sum_product_reg + SQ_W'(s1_ab_reg);
            end
        end
    end

    // Magnitudes of the signed sums
    logic [SUM_W-1:0] abs_sa, abs_sb;
    logic [SQ_W-1:0]  abs_sab;

    assign abs_sa  = sum_a_reg[SUM_W-1] ? (~sum_a_reg + SUM_W'(1)) : sum_a_reg;
    assign abs_sb  = sum_b_reg[SUM_W-1] ? (~sum_b_reg + SUM_W'(1)) : sum_b_reg;
    assign abs_sab = sum_product_reg[SQ_W-1] ? (~sum_product_reg + SQ_W'(1))
                                             : sum_product_reg;

    logic [VAR_W-1:0] tmp_reg, va_reg, vb_reg, num_reg;
    logic [PROD_W-1:0] p_reg, x_reg;
    logic [VAR_W-1:0] mag;

    assign mag = num_reg[VAR_W-1] ? (~num_reg + VAR_W'(1)) : num_reg;

    // Select multiplier operands and product sign
    logic [MUL_W-1:0] opa, opb;
    logic             op_neg;

    always_comb
    begin
        opa    = '0;
        opb    = '0;
        op_neg = 1'b0;
        case (cmd.op)
            OP_NSAA:
            begin
                opa = MUL_W'(pair_count_reg);
                opb = MUL_W'(sum_sq_a_reg);
            end
            OP_SASA:
            begin
                opa = MUL_W'(abs_sa);
                opb = MUL_W'(abs_sa);
            end
            OP_NSBB:
            begin
                opa = MUL_W'(pair_count_reg);
                opb = MUL_W'(sum_sq_b_reg);
            end
            OP_SBSB:
            begin
                opa = MUL_W'(abs_sb);
                opb = MUL_W'(abs_sb);
            end
            OP_NSAB:
            begin
                opa    = MUL_W'(pair_count_reg);
                opb    = MUL_W'(abs_sab);
                op_neg = sum_product_reg[SQ_W-1];
            end
            OP_SASB:
            begin
                opa    = MUL_W'(abs_sa);
                opb    = MUL_W'(abs_sb);
                op_neg = sum_a_reg[SUM_W-1] ^ sum_b_reg[SUM_W-1];
            end
            OP_VAVB:
            begin
                opa = va_reg[MUL_W-1:0];
                opb = vb_reg[MUL_W-1:0];
            end
            OP_MAG2:
            begin
                opa = mag[MUL_W-1:0];
                opb = mag[MUL_W-1:0];
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    // Shift-add multiplier: one multiplier bit per cycle
    logic [MUL_W-1:0]  mcand_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic [MUL_W:0]    mul_sum;

    assign mul_sum = {1'b0, prod_reg[PROD_W-1:MUL_W]}
                   + {1'b0, (prod_reg[0] ? mcand_reg : MUL_W'(0))};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            mcand_reg <= opa;
            prod_reg  <= {MUL_W'(0), opb};
            neg_reg   <= op_neg;
        end
        else if (cmd.mul_step)
        begin
            prod_reg <= {mul_sum, prod_reg[MUL_W-1:1]};
        end
    end

    // Fold products into variances, numerator and the two wide terms
    logic [VAR_W-1:0] sprod;

    assign sprod = neg_reg ? (~prod_reg[VAR_W-1:0] + VAR_W'(1)) : prod_reg[VAR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_capture)
        begin
            case (cmd.op)
                OP_NSAA, OP_NSBB, OP_NSAB: tmp_reg <= sprod;
                OP_SASA: va_reg  <= tmp_reg - sprod;
                OP_SBSB: vb_reg  <= tmp_reg - sprod;
                OP_SASB: num_reg <= tmp_reg - sprod;
                OP_VAVB: p_reg   <= prod_reg;
                OP_MAG2: x_reg   <= prod_reg;
                default: tmp_reg <= sprod;
            endcase
        end
    end

    assign stat.zero_var = (va_reg == '0) || (vb_reg == '0);

    // Restoring divider: floor(mag^2 * 2^30 / (va * vb)), one bit per cycle
    logic [REM_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [REM_W:0]   div_diff;
    logic             div_ge;
    logic [REM_W-1:0] rem_keep;

    assign div_diff = {1'b0, rem_reg} - {2'b00, p_reg};
    assign div_ge   = !div_diff[REM_W];
    assign rem_keep = div_ge ? div_diff[REM_W-1:0] : rem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= {1'b0, x_reg};
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= {rem_keep[REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
        end
    end

    // Integer square root of the quotient, one root bit per cycle
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W-1:0]   cand;
    logic [2*ROOT_W-1:0] cand_sq;

    assign cand    = root_reg | (ROOT_W'(1) << cmd.sqrt_bit);
    assign cand_sq = cand * cand;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            root_reg <= '0;
        end
        else if (cmd.sqrt_step && (cand_sq <= (2*ROOT_W)'(quo_reg)))
        begin
            root_reg <= cand;
        end
    end

    // Output register: sign, clamp and hold until taken
    logic        out_valid_reg;
    logic [15:0] corr_next;

    always_comb
    begin
        if (stat.zero_var)
        begin
            corr_next = '0;
        end
        else if (num_reg[VAR_W-1])
        begin
            corr_next = ~root_reg + 16'd1;
        end
        else if (root_reg[ROOT_W-1])
        begin
            corr_next = 16'h7FFF;
        end
        else
        begin
            corr_next = root_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    logic signed [15:0] corr_reg;
    logic               zv_reg, tms_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            corr_reg <= $signed(corr_next);
            zv_reg   <= stat.zero_var;
            tms_reg  <= overflow_seen_reg;
        end
    end

    assign stat.out_free    = !out_valid_reg || !out_stall;
    assign out_valid        = out_valid_reg;
    assign correlation      = corr_reg;
    assign zero_variance    = zv_reg;
    assign too_many_samples = tms_reg;

endmodule

### hdl/pearson_correlation_unit_core.sv
// Top level of the Pearson correlation unit: controller plus datapath.
`timescale 1ns / 1ps

// Sample pairs are taken one per clock while the unit is accumulating; the
// pair flagged last_sample ends the vector. After that pair the input stalls
// while one shared shift-add multiplier evaluates eight products in turn, a
// restoring divider produces 31 quotient bits and a bit-serial root finder
// produces 16 root bits. When either variance is zero the divider and root
// are skipped. The result then sits in an output register until taken, and
// accumulation of the next vector resumes as soon as that register can
// accept it; a previous result still held there by out_stall lengthens the
// stall by the cycles it waits. Up to 1024 pairs per vector are kept; later
// ones are dropped and reported through too_many_samples.

module pearson_correlation_unit_core
    import pcu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] sample_a,
    input  logic signed [15:0] sample_b,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] correlation,
    output logic               zero_variance,
    output logic               too_many_samples
);

    pcu_cmd_t  cmd;
    pcu_stat_t stat;

    pcu_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_sample (last_sample),
        .stat        (stat),
        .in_stall    (in_stall),
        .cmd         (cmd)
    );

    pcu_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_a         (sample_a),
        .sample_b         (sample_b),
        .cmd              (cmd),
        .stat             (stat),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .correlation      (correlation),
        .zero_variance    (zero_variance),
        .too_many_samples (too_many_samples)
    );

endmodule

### hdl/pcu_checker.sv
// Port-level checker of the Pearson correlation unit and its bind.
`timescale 1ns / 1ps

`include "pearson_correlation_unit_core_assert.svh"

module pcu_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic signed [15:0] sample_a,
    input logic signed [15:0] sample_b,
    input logic               last_sample,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] correlation,
    input logic               zero_variance,
    input logic               too_many_samples
);

    // A stalled result transaction stays valid and keeps its coefficient and zero-variance flag
    `PCU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(correlation) && $stable(zero_variance), "stalled result changed")

    // A zero-variance result carries a zero coefficient
    `PCU_ASSERT_NOW(a_zv_zero, out_valid && zero_variance, correlation == 16'sd0, "zero variance with nonzero correlation")

    // The last pair of a vector closes the input for evaluation
    `PCU_ASSERT_NEXT(a_last_stall, in_valid && !in_stall && last_sample, in_stall, "input open after last pair")

    // The evaluation does not hand out its result right after the last pair
    `PCU_ASSERT_NEXT(a_no_early, in_valid && !in_stall && last_sample, in_stall && !$rose(out_valid), "result too early")

endmodule

bind pearson_correlation_unit_core pcu_checker u_pcu_checker (.*);

### sim/tb_pearson_correlation_unit_core.sv
// Testbench of the Pearson correlation unit: random and directed vectors vs. a predictor.
`timescale 1ns / 1ps

module tb_pearson_correlation_unit_core;
    import pcu_pkg::*;

    typedef struct {
        logic signed [15:0] corr;
        logic               zero_var;
        logic               dropped;
    } corr_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic               last_sample;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] correlation;
    logic               zero_variance;
    logic               too_many_samples;

    // Predictor state
    int           pairs_kept;
    longint       acc_a, acc_b, acc_aa, acc_bb, acc_ab;
    bit           pairs_dropped;
    corr_result_t pending_results[$];

    int idle_pct;
    int stall_pct;
    int fail_count;

    pearson_correlation_unit_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample_a         (sample_a),
        .sample_b         (sample_b),
        .last_sample      (last_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .correlation      (correlation),
        .zero_variance    (zero_variance),
        .too_many_samples (too_many_samples)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // End the run as failed if something hangs
    initial
    begin
        #100ms;
        $display("TEST FAILED");
        $finish;
    end

    // Largest q with q*sqrt(va*vb) <= mag*32768, by exact wide comparison
    function automatic logic [63:0] scaled_ratio(logic [63:0] mag, logic [63:0] va,
                                                 logic [63:0] vb);
        logic [255:0] prod_v;
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] wide;
        logic [63:0]  q;
        logic [63:0]  cand;
        q = '0;
        wide = {192'b0, va};
        prod_v = wide * {192'b0, vb};
        wide = {192'b0, mag};
        rhs = (wide * wide) << 30;
        for (int bitpos = 16; bitpos >= 0; bitpos--)
        begin
            cand = q | (64'd1 << bitpos);
            lhs = prod_v * {192'b0, cand * cand};
            if (lhs <= rhs)
                q = cand;
        end
        return q;
    endfunction

    // Accumulate one pair; on the last pair queue the expected coefficient
    task automatic predict_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
        longint       va, vb, num;
        logic [63:0]  mag;
        logic [63:0]  q;
        corr_result_t r;
        if (pairs_kept >= MAX_SAMPLES)
            pairs_dropped = 1'b1;
        else
        begin
            pairs_kept++;
            acc_a  += a;
            acc_b  += b;
            acc_aa += longint'(a) * a;
            acc_bb += longint'(b) * b;
            acc_ab += longint'(a) * b;
        end
        if (!last)
            return;
        va  = pairs_kept * acc_aa - acc_a * acc_a;
        vb  = pairs_kept * acc_bb - acc_b * acc_b;
        num = pairs_kept * acc_ab - acc_a * acc_b;
        r.corr = '0;
        r.zero_var = (va == 0 || vb == 0);
        r.dropped = pairs_dropped;
        if (!r.zero_var)
        begin
            mag = (num < 0) ? -num : num;
            q = scaled_ratio(mag, va, vb);
            if (num < 0)
            begin
                if (q > 32768)
                    q = 32768;
                r.corr = -q[15:0];
            end
            else
            begin
                if (q > 32767)
                    q = 32767;
                r.corr = q[15:0];
            end
        end
        pending_results.push_back(r);
        pairs_kept = 0;
        acc_a = 0; acc_b = 0; acc_aa = 0; acc_bb = 0; acc_ab = 0;
        pairs_dropped = 1'b0;
    endtask

    // Send one pair and wait for the transaction
    task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_a    <= a;
        sample_b    <= b;
        last_sample <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pair(a, b, last);
    endtask

    // Pause the sender until every expected transaction has come out
    task automatic drain;
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (600) @(posedge clk);
    endtask

    // Random vector, mostly short, with assorted value ranges
    task automatic send_random_vector(int len);
        int mode;
        logic signed [15:0] a, b;
        mode = $urandom_range(5);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0:
                begin
                    a = 16'(int'($urandom_range(255)) - 128);
                    b = 16'(int'($urandom_range(255)) - 128);
                end
                1:
                begin
                    a = 16'($urandom);
                    b = a + 16'(int'($urandom_range(63)) - 32);
                end
                2:
                begin
                    a = 16'($urandom);
                    b = -a + 16'(int'($urandom_range(63)) - 32);
                end
                3:
                begin
                    a = 16'sd77;
                    b = 16'($urandom);
                end
                default:
                begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                end
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic test_directed;
        // single pair: zero variance
        send_pair(16'sh7FFF, -16'sh8000, 1'b1);
        // constant sample_a: zero variance
        send_pair(16'sd5, 16'sd1, 1'b0);
        send_pair(16'sd5, 16'sd2, 1'b1);
        // perfect positive correlation saturates
        send_pair(-16'sh8000, -16'sh8000, 1'b0);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        // near-perfect negative correlation
        send_pair(-16'sh8000, 16'sh7FFF, 1'b0);
        send_pair(16'sh7FFF, -16'sh8000, 1'b0);
        send_pair(16'sd0, 16'sd0, 1'b1);
        // mixed extremes
        send_pair(16'sh7FFF, 16'sd0, 1'b0);
        send_pair(-16'sh8000, 16'sd1, 1'b0);
        send_pair(16'sd0, -16'sd1, 1'b0);
        send_pair(-16'sd1, 16'sh7FFF, 1'b1);
        drain();
    endtask

    // Overflow the sample limit, the dropped pair carrying the last flag
    task automatic test_sample_limit;
        for (int i = 0; i < MAX_SAMPLES + 2; i++)
            send_pair(16'($urandom), 16'($urandom), i == MAX_SAMPLES + 1);
        // the next vector must start clean
        send_pair(16'sd3, 16'sd9, 1'b0);
        send_pair(16'sd4, 16'sd1, 1'b1);
        drain();
    endtask

    task automatic test_random(int ipct, int spct, int items);
        int sent;
        int len;
        idle_pct = ipct;
        stall_pct = spct;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200, 60)
                                           : $urandom_range(24, 2);
            send_random_vector(len);
            sent += len;
        end
        drain();
    endtask

    // Receiver stall pattern
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        corr_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction");
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (correlation !== exp_r.corr)
                begin
                    $error("correlation: expected %0d, got %0d", exp_r.corr, correlation);
                    fail_count++;
                end
                if (zero_variance !== exp_r.zero_var)
                begin
                    $error("zero_variance: expected %0b, got %0b", exp_r.zero_var,
                           zero_variance);
                    fail_count++;
                end
                if (too_many_samples !== exp_r.dropped)
                begin
                    $error("too_many_samples: expected %0b, got %0b", exp_r.dropped,
                           too_many_samples);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_a = '0;
        sample_b = '0;
        last_sample = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        fail_count = 0;
        pairs_kept = 0;
        acc_a = 0; acc_b = 0; acc_aa = 0; acc_bb = 0; acc_ab = 0;
        pairs_dropped = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_sample_limit();
        test_random(0, 0, 170);
        test_random(82, 0, 160);
        test_random(0, 82, 160);
        test_random(21, 21, 170);

        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/pcu_pkg.sv
hdl/pcu_ctrl.sv
hdl/pcu_datapath.sv
hdl/pearson_correlation_unit_core.sv
hdl/pcu_checker.sv
sim/tb_pearson_correlation_unit_core.sv
